>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define HST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define HST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg
// Widths, codes and record types shared by the score table modules.
// ----------------------------------------------------------------------------
package hst_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 65536;
  localparam int unsigned FILL_SAMPLE_DEF = 1000;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned FLAG_W  = 2;
  localparam int unsigned MOVE_W  = 22;
  localparam int unsigned FILL_W  = 10;
  localparam int unsigned CFG_W   = 17;

  // The index is zero or below the capped count, so it fits the register width.
  localparam int unsigned IDX_W  = CFG_W;
  localparam int unsigned PROD_W = HALF_W + CFG_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [KIND_W-1:0] KIND_LOOKUP     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STORE      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STORE_KEEP = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FILL       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_STORE,
    OP_STORE_KEEP,
    OP_FILL,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [MOVE_W-1:0]         move;
    logic [FLAG_W-1:0]         flag;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
  } slot_t;

  typedef struct packed {
    op_t                       op;
    logic [IDX_W-1:0]          idx;
    logic [TAG_W-1:0]          tag;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [FLAG_W-1:0]         flag;
    logic [MOVE_W-1:0]         move;
  } entry_t;

  typedef struct packed {
    logic                      hit;
    logic [FLAG_W-1:0]         flag;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
    logic [FILL_W-1:0]         fill;
  } result_t;

endpackage

>>> src/hst_item_if.sv
// ----------------------------------------------------------------------------
// hst_item_if
// Request channel of the score table: one command per transaction.
// ----------------------------------------------------------------------------
interface hst_item_if import hst_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [KEY_W-1:0]          key;
  logic [FLAG_W-1:0]         bound_flag;
  logic [DEPTH_W-1:0]        search_depth;
  logic signed [SCORE_W-1:0] score_value;
  logic [MOVE_W-1:0]         move_code;

  modport source (
    output valid, kind, key, bound_flag, search_depth, score_value, move_code,
    input  ready
  );
  modport sink (
    input  valid, kind, key, bound_flag, search_depth, score_value, move_code,
    output ready
  );
endinterface

>>> src/hst_result_if.sv
// ----------------------------------------------------------------------------
// hst_result_if
// Response channel of the score table: one result per transaction.
// ----------------------------------------------------------------------------
interface hst_result_if import hst_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [FLAG_W-1:0]         found_flag;
  logic [DEPTH_W-1:0]        found_depth;
  logic signed [SCORE_W-1:0] found_score;
  logic [MOVE_W-1:0]         found_move;
  logic [FILL_W-1:0]         fill_per_mille;

  modport source (
    output valid, hit, found_flag, found_depth, found_score, found_move, fill_per_mille,
    input  ready
  );
  modport sink (
    input  valid, hit, found_flag, found_depth, found_score, found_move, fill_per_mille,
    output ready
  );
endinterface

>>> src/hst_cfg_if.sv
// ----------------------------------------------------------------------------
// hst_cfg_if
// Configuration write channel carrying the entries_in_use register.
// ----------------------------------------------------------------------------
interface hst_cfg_if import hst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] entries_in_use;

  modport source (output valid, entries_in_use, input ready);
  modport sink   (input valid, entries_in_use, output ready);
endinterface

>>> src/hst_front.sv
// ----------------------------------------------------------------------------
// hst_front
// Accepts commands, decodes them and computes the slot index in two stages.
// ----------------------------------------------------------------------------
module hst_front import hst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  hst_item_if.sink         in_item,
  input  logic [CFG_W-1:0] entries_in_use,
  input  logic             enable,
  output logic             q_valid,
  output entry_t           q_data,
  input  logic             q_ready
);

  localparam int unsigned AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned IFULL_W = SUM_W - HALF_W;
  localparam int unsigned CMP_W   = (AW + 1 > IFULL_W) ? AW + 1 : IFULL_W;

  logic               s1_v_r, s1_v_nxt;
  logic               s2_v_r, s2_v_nxt;
  entry_t             s1_ent_r, s2_ent_r;
  logic [KEY_W-1:0]   s1_key_r;
  logic [PROD_W-1:0]  prod_hi_r, prod_lo_r;
  logic [CFG_W-1:0]   eff_entries;
  logic [SUM_W-1:0]   idx_sum;
  logic [IFULL_W-1:0] idx_full;
  logic [IDX_W-1:0]   idx;
  logic               in_acc, s2_free, s1_go;
  entry_t             in_ent;

  function automatic op_t decode_kind(input logic [KIND_W-1:0] kind);
    op_t op;
    unique case (kind)
      KIND_LOOKUP:     op = OP_LOOKUP;
      KIND_STORE:      op = OP_STORE;
      KIND_STORE_KEEP: op = OP_STORE_KEEP;
      KIND_FILL:       op = OP_FILL;
      KIND_CLEAR:      op = OP_CLEAR;
      default:         op = OP_NOP;
    endcase
    return op;
  endfunction

  assign s2_free = !s2_v_r || q_ready;
  assign s1_go   = s1_v_r && s2_free;
  assign in_item.ready = enable && (!s1_v_r || s2_free);
  assign in_acc  = in_item.valid && in_item.ready;

  always_comb begin
    in_ent       = '0;
    in_ent.op    = decode_kind(in_item.kind);
    in_ent.tag   = in_item.key[TAG_W-1:0];
    in_ent.score = in_item.score_value;
    in_ent.depth = in_item.search_depth;
    in_ent.flag  = in_item.bound_flag;
    in_ent.move  = in_item.move_code;
  end

  // Entry count is capped at the physical depth.
  assign eff_entries = (CMP_W'(entries_in_use) > CMP_W'(TABLE_DEPTH)) ?
                       CFG_W'(TABLE_DEPTH) : entries_in_use;

  assign idx_sum  = SUM_W'(prod_hi_r) + SUM_W'(prod_lo_r[PROD_W-1:HALF_W]);
  assign idx_full = idx_sum[SUM_W-1:HALF_W];
  assign idx      = (CMP_W'(idx_full) >= CMP_W'(TABLE_DEPTH)) ?
                    IDX_W'(TABLE_DEPTH - 1) : IDX_W'(idx_full);

  assign s1_v_nxt = in_acc || (s1_v_r && !s2_free);
  assign s2_v_nxt = s1_go || (s2_v_r && !q_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ent_r <= in_ent;
      s1_key_r <= in_item.key;
    end
    if (s1_go) begin
      s2_ent_r  <= s1_ent_r;
      prod_hi_r <= PROD_W'(s1_key_r[KEY_W-1:HALF_W]) * PROD_W'(eff_entries);
      prod_lo_r <= PROD_W'(s1_key_r[HALF_W-1:0]) * PROD_W'(eff_entries);
    end
  end

  always_comb begin
    q_data     = s2_ent_r;
    q_data.idx = idx;
  end
  assign q_valid = s2_v_r;

endmodule

>>> src/hst_queue.sv
// ----------------------------------------------------------------------------
// hst_queue
// Small FIFO of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
module hst_queue import hst_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  input  entry_t push_data,
  output logic   push_ready,
  output logic   pop_valid,
  output entry_t pop_data,
  input  logic   pop_ready
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/hst_back.sv
// ----------------------------------------------------------------------------
// hst_back
// Owns the slot memory and executes commands: read-modify-write, sweeps, result.
// ----------------------------------------------------------------------------
module hst_back import hst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned FILL_SAMPLE = FILL_SAMPLE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  entry_t     q_data,
  output logic       q_ready,
  output logic       init_done,
  hst_result_if.source out_result
);

  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned FILL_N = (FILL_SAMPLE < TABLE_DEPTH) ? FILL_SAMPLE : TABLE_DEPTH;

  typedef enum logic [5:0] {
    ST_INIT      = 6'b000001,
    ST_IDLE      = 6'b000010,
    ST_EXEC      = 6'b000100,
    ST_FILL      = 6'b001000,
    ST_FILL_LAST = 6'b010000,
    ST_CLEAR     = 6'b100000
  } state_t;

  slot_t             mem [TABLE_DEPTH];
  slot_t             rd_data_r;
  state_t            state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [FILL_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic              init_done_r, init_done_nxt;
  logic              res_valid_r, res_valid_nxt;
  result_t           res_r, res_nxt;
  entry_t            ent_r, ent_nxt;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  slot_t             mem_wdata;
  logic              slot_free, tag_match, sweep_last, fill_last;

  assign slot_free  = !res_valid_r || out_result.ready;
  assign tag_match  = (rd_data_r.tag == ent_r.tag);
  assign sweep_last = (cnt_r == AW'(TABLE_DEPTH - 1));
  assign fill_last  = (cnt_r == AW'(FILL_N - 1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_cnt_nxt  = fill_cnt_r;
    init_done_nxt = init_done_r;
    res_valid_nxt = res_valid_r && !out_result.ready;
    res_nxt       = res_r;
    ent_nxt       = ent_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = cnt_r;
    mem_raddr     = cnt_r;
    mem_wdata     = '0;
    q_ready       = 1'b0;

    unique case (state_r)
      ST_INIT: begin
        mem_we = 1'b1;
        if (sweep_last) begin
          cnt_nxt       = '0;
          init_done_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          ent_nxt = q_data;
          unique case (q_data.op)
            OP_LOOKUP, OP_STORE, OP_STORE_KEEP: begin
              mem_re    = 1'b1;
              mem_raddr = AW'(q_data.idx);
              state_nxt = ST_EXEC;
            end
            OP_FILL: begin
              cnt_nxt      = '0;
              fill_cnt_nxt = '0;
              state_nxt    = ST_FILL;
            end
            OP_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_EXEC;
            end
          endcase
        end
      end

      ST_FILL: begin
        mem_re = 1'b1;
        // The registered read data belongs to the previous address.
        if ((cnt_r != '0) && (rd_data_r.tag != '0)) begin
          fill_cnt_nxt = fill_cnt_r + 1'b1;
        end
        if (fill_last) begin
          state_nxt = ST_FILL_LAST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_FILL_LAST: begin
        if (rd_data_r.tag != '0) begin
          fill_cnt_nxt = fill_cnt_r + 1'b1;
        end
        cnt_nxt   = '0;
        state_nxt = ST_EXEC;
      end

      ST_CLEAR: begin
        mem_we = 1'b1;
        if (sweep_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_EXEC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_EXEC: begin
        if (slot_free) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '0;
          state_nxt     = ST_IDLE;
          mem_waddr     = AW'(ent_r.idx);
          mem_wdata.tag   = ent_r.tag;
          mem_wdata.score = ent_r.score;
          mem_wdata.depth = ent_r.depth;
          mem_wdata.flag  = ent_r.flag;
          mem_wdata.move  = ent_r.move;
          unique case (ent_r.op)
            OP_LOOKUP: begin
              if (tag_match) begin
                res_nxt.hit   = 1'b1;
                res_nxt.flag  = rd_data_r.flag;
                res_nxt.depth = rd_data_r.depth;
                res_nxt.score = rd_data_r.score;
                res_nxt.move  = rd_data_r.move;
              end
            end
            OP_STORE: begin
              mem_we = 1'b1;
            end
            OP_STORE_KEEP: begin
              mem_we         = 1'b1;
              mem_wdata.move = tag_match ? rd_data_r.move : '0;
            end
            OP_FILL: begin
              res_nxt.fill = fill_cnt_r;
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      fill_cnt_r  <= '0;
      init_done_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      init_done_r <= init_done_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign init_done                 = init_done_r;
  assign out_result.valid          = res_valid_r;
  assign out_result.hit            = res_r.hit;
  assign out_result.found_flag     = res_r.flag;
  assign out_result.found_depth    = res_r.depth;
  assign out_result.found_score    = res_r.score;
  assign out_result.found_move     = res_r.move;
  assign out_result.fill_per_mille = res_r.fill;

endmodule

>>> src/hashed_score_table.sv
// ----------------------------------------------------------------------------
// hashed_score_table
// Direct-mapped, always-replace score table keyed by a 64-bit hash key.
// ----------------------------------------------------------------------------
// Every command transaction on in_item produces exactly one result transaction
// on out_result, in command order. A command passes through a two-stage front
// end (decode, then the multiply-high index reduction key * entries_in_use),
// a two-entry command queue, and a back end that owns the single-port slot
// memory. In the back end a lookup or a store reads the slot in ST_IDLE and
// writes it back and posts the result in ST_EXEC, so the back end takes no
// new command until the read-modify-write of the last one is done. A fill
// query reads the first FILL_SAMPLE slots (at most TABLE_DEPTH) one per cycle;
// a clear writes zero to every slot. After reset the back end runs a clearing
// pass, one slot per cycle; in_item.ready stays low until it completes, while
// configuration writes are taken at any time. The user must see that
// entries_in_use is written only while no command is in flight; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module hashed_score_table import hst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned FILL_SAMPLE = FILL_SAMPLE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  hst_item_if.sink     in_item,
  hst_result_if.source out_result,
  hst_cfg_if.sink      cfg_wr
);

  // Slot count register used by the index reduction. Values above the
  // physical depth are capped in the front end; zero sends every key to slot 0.
  logic [CFG_W-1:0] entries_r, entries_nxt;

  // Decoded command path from the front end through the queue to the back end.
  logic   fq_valid, fq_ready;
  entry_t fq_data;
  logic   qb_valid, qb_ready;
  entry_t qb_data;

  // High once the clearing pass after reset has finished.
  logic   init_done;

  // The register can always be written; commands not yet multiplied use it.
  assign cfg_wr.ready = 1'b1;
  assign entries_nxt  = (cfg_wr.valid && cfg_wr.ready) ? cfg_wr.entries_in_use : entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CFG_RESET;
    end else begin
      entries_r <= entries_nxt;
    end
  end

  // Front end: accepts commands and computes the slot index and tag.
  hst_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_item        (in_item),
    .entries_in_use (entries_r),
    .enable         (init_done),
    .q_valid        (fq_valid),
    .q_data         (fq_data),
    .q_ready        (fq_ready)
  );

  // Queue: lets the front end keep accepting while the back end is busy
  // with a sweep or waiting for the result to be taken.
  hst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_data  (fq_data),
    .push_ready (fq_ready),
    .pop_valid  (qb_valid),
    .pop_data   (qb_data),
    .pop_ready  (qb_ready)
  );

  // Back end: memory owner. The result register sits at its output, so a
  // finished result can wait for out_result.ready without blocking the front.
  hst_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FILL_SAMPLE (FILL_SAMPLE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_data     (qb_data),
    .q_ready    (qb_ready),
    .init_done  (init_done),
    .out_result (out_result)
  );

endmodule

>>> src/hst_checker.sv
// ----------------------------------------------------------------------------
// hst_checker
// Port-level checks of the score table, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hst_checker import hst_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_hit,
  input logic [FLAG_W-1:0]         out_flag,
  input logic [DEPTH_W-1:0]        out_depth,
  input logic signed [SCORE_W-1:0] out_score,
  input logic [MOVE_W-1:0]         out_move,
  input logic [FILL_W-1:0]         out_fill
);

  // Two front stages, the queue, the back end and the result register.
  localparam int unsigned MAX_IN_FLIGHT = 4 + QUEUE_DEPTH;
  localparam int unsigned PEND_W        = $clog2(MAX_IN_FLIGHT + 2);

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [FLAG_W+DEPTH_W+SCORE_W+MOVE_W+FILL_W:0] out_bits;

  assign out_bits = {out_hit, out_flag, out_depth, out_score, out_move, out_fill};
  assign pend_nxt = pend_r + PEND_W'(in_valid && in_ready) - PEND_W'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `HST_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_bits), "stalled result changed or dropped")
  `HST_ASSERT(a_no_extra_result, clk, rst_n, out_valid |-> pend_r != '0, "result without an outstanding command")
  `HST_ASSERT(a_in_flight_bound, clk, rst_n, pend_r <= PEND_W'(MAX_IN_FLIGHT), "too many commands in flight")
  `HST_ASSERT_ALWAYS(a_reset_blocks_input, clk, !rst_n |=> !in_ready, "input taken during clearing pass")

endmodule

bind hashed_score_table hst_checker u_hst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_item.valid),
  .in_ready  (in_item.ready),
  .out_valid (out_result.valid),
  .out_ready (out_result.ready),
  .out_hit   (out_result.hit),
  .out_flag  (out_result.found_flag),
  .out_depth (out_result.found_depth),
  .out_score (out_result.found_score),
  .out_move  (out_result.found_move),
  .out_fill  (out_result.fill_per_mille)
);
